// File: rtl/core/ofvi_pkg.sv
// ----------------------------------------------------------------------------
// ofvi_pkg
// shared types and constants of the face vertex indexer
// ----------------------------------------------------------------------------
package ofvi_pkg;

   localparam int IDX_W  = 20;          // resolved one-based index width
   localparam int REF_W  = 21;          // raw signed reference width
   localparam int KEY_W  = 3 * IDX_W;   // {normal, texcoord, position}
   localparam int VID_W  = 12;          // vertex index width on the result port

   localparam int DEF_MAX_FACE_VERTS = 16;
   localparam int DEF_MAX_VERTICES   = 4096;
   localparam int DEF_INDEX_BITS     = 20;

   typedef enum logic [1:0] {
      CMD_POS    = 2'd0,
      CMD_UV     = 2'd1,
      CMD_NORMAL = 2'd2,
      CMD_FACE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_VERTEX   = 2'd0,
      KIND_TRI      = 2'd1,
      KIND_INVALID  = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_P_LOAD,
      S_P_HASH,
      S_P_RD,
      S_P_CHK,
      S_RB_LOAD,
      S_RB_DO,
      S_R_LOAD,
      S_R_OUT,
      S_T_LD1,
      S_T_PREV,
      S_T_LD,
      S_T_OUT,
      S_ONE
   } state_type;

endpackage

// File: rtl/core/ofvi_key_table.sv
// ----------------------------------------------------------------------------
// ofvi_key_table
// open-addressed key table: valid bit, 60-bit key and vertex index per slot
// ----------------------------------------------------------------------------
module ofvi_key_table #(
   parameter int HASH_BITS = 13,
   parameter int VIDX_BITS = 12
) (
   input  logic                       clock,
   input  logic [HASH_BITS-1:0]       rd_addr,
   output logic                       rd_valid,
   output logic [ofvi_pkg::KEY_W-1:0] rd_key,
   output logic [VIDX_BITS-1:0]       rd_idx,
   input  logic                       wr_en,
   input  logic [HASH_BITS-1:0]       wr_addr,
   input  logic                       wr_valid,
   input  logic [ofvi_pkg::KEY_W-1:0] wr_key,
   input  logic [VIDX_BITS-1:0]       wr_idx
);

   localparam int ENTRY_W = 1 + ofvi_pkg::KEY_W + VIDX_BITS;
   localparam int DEPTH   = 1 << HASH_BITS;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_valid, wr_key, wr_idx};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_valid = rd_data_ff[ENTRY_W-1];
   assign rd_key   = rd_data_ff[ENTRY_W-2 -: ofvi_pkg::KEY_W];
   assign rd_idx   = rd_data_ff[VIDX_BITS-1:0];

endmodule

// File: rtl/core/ofvi_face_store.sv
// ----------------------------------------------------------------------------
// ofvi_face_store
// per-face buffers: resolved triples and per-corner lookup results
// ----------------------------------------------------------------------------
module ofvi_face_store #(
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4,
   parameter int INFO_BITS = 26
) (
   input  logic                       clock,
   input  logic                       trip_we,
   input  logic [ADDR_BITS-1:0]       trip_waddr,
   input  logic [ofvi_pkg::KEY_W-1:0] trip_wdata,
   input  logic                       info_we,
   input  logic [ADDR_BITS-1:0]       info_waddr,
   input  logic [INFO_BITS-1:0]       info_wdata,
   input  logic [ADDR_BITS-1:0]       rd_addr,
   output logic [ofvi_pkg::KEY_W-1:0] trip_rdata,
   output logic [INFO_BITS-1:0]       info_rdata
);

   logic [ofvi_pkg::KEY_W-1:0] trip_mem [DEPTH];
   logic [INFO_BITS-1:0]       info_mem [DEPTH];
   logic [ofvi_pkg::KEY_W-1:0] trip_rd_ff;
   logic [INFO_BITS-1:0]       info_rd_ff;

   always_ff @(posedge clock) begin
      if (trip_we) begin
         trip_mem[trip_waddr] <= trip_wdata;
      end
      if (info_we) begin
         info_mem[info_waddr] <= info_wdata;
      end
      trip_rd_ff <= trip_mem[rd_addr];
      info_rd_ff <= info_mem[rd_addr];
   end

   assign trip_rdata = trip_rd_ff;
   assign info_rdata = info_rd_ff;

endmodule

// File: rtl/core/obj_face_vertex_indexer_unit.sv
// ----------------------------------------------------------------------------
// obj_face_vertex_indexer_unit
// counts declarations, buffers face references and deduplicates vertex
// triples through a hashed key table, then emits new vertices and fan
// triangles
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------
//  req_     | in        | req_valid/req_stall| cmd, pos/uv/normal ref, last
//  rsp_     | out       | rsp_valid/rsp_stall| kind, vertex record, corners
//
//  declarations and non-final face references leave the sequencer idle
//  face end: each buffered triple is loaded, hashed and checked in the key table,
//  with another read per collision probe, then vertex records, then triangles
//  a rejected face gives one result; an overflow found mid-walk rolls back first
//  reset clears all 2^(clog2(MAX_VERTICES)+1) key table slots (8192)
//  req_stall is high whenever the sequencer is not idle; rsp_stall holds it longer
//
module obj_face_vertex_indexer_unit #(
   parameter int MAX_FACE_VERTS = ofvi_pkg::DEF_MAX_FACE_VERTS,
   parameter int MAX_VERTICES   = ofvi_pkg::DEF_MAX_VERTICES,
   parameter int INDEX_BITS     = ofvi_pkg::DEF_INDEX_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_cmd,
   input  logic signed [ofvi_pkg::REF_W-1:0] req_pos_ref,
   input  logic signed [ofvi_pkg::REF_W-1:0] req_uv_ref,
   input  logic signed [ofvi_pkg::REF_W-1:0] req_normal_ref,
   input  logic                       req_face_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_kind,
   output logic [ofvi_pkg::VID_W-1:0] rsp_new_vertex_index,
   output logic [ofvi_pkg::IDX_W-1:0] rsp_pos_index,
   output logic [ofvi_pkg::IDX_W-1:0] rsp_uv_index,
   output logic [ofvi_pkg::IDX_W-1:0] rsp_normal_index,
   output logic [ofvi_pkg::VID_W-1:0] rsp_corner_a,
   output logic [ofvi_pkg::VID_W-1:0] rsp_corner_b,
   output logic [ofvi_pkg::VID_W-1:0] rsp_corner_c,
   output logic                       rsp_run_last
);

   localparam int IW  = ofvi_pkg::IDX_W;
   localparam int KW  = ofvi_pkg::KEY_W;
   localparam int VW  = ofvi_pkg::VID_W;
   localparam int VB  = $clog2(MAX_VERTICES);       // vertex index bits
   localparam int HB  = VB + 1;                     // key table address bits
   localparam int TB  = $clog2(MAX_VERTICES + 1);   // vertex total bits
   localparam int LB  = $clog2(MAX_FACE_VERTS + 2); // face length bits
   localparam int PB  = $clog2(MAX_FACE_VERTS);     // face buffer address bits
   localparam int FB  = $clog2(MAX_FACE_VERTS + 1); // per-face fresh count bits
   localparam int INFO_W = 1 + HB + VB;             // {fresh, slot, index}
   localparam logic [IW-1:0] COUNT_MAX = IW'((1 << INDEX_BITS) - 1);

   // xor fold of the key onto the table address
   function automatic logic [HB-1:0] key_hash(input logic [KW-1:0] k);
      logic [HB-1:0] h;
      h = '0;
      for (int b = 0; b < KW; b++) begin
         h[b % HB] = h[b % HB] ^ k[b];
      end
      return h;
   endfunction

   // relative references count back from the latest declaration
   function automatic logic [22:0] resolve(input logic [20:0] raw,
                                           input logic [IW-1:0] cnt);
      logic [22:0] r;
      logic [22:0] c;
      r = {{2{raw[20]}}, raw};
      c = {3'b000, cnt};
      return raw[20] ? (c + r + 23'd1) : r;
   endfunction

   ofvi_pkg::state_type state_ff, state_in;

   logic [HB-1:0]  clr_ff, clr_in;
   logic [IW-1:0]  pcnt_ff, pcnt_in, tcnt_ff, tcnt_in, ncnt_ff, ncnt_in;
   logic [LB-1:0]  face_len_ff, face_len_in;
   logic           face_bad_ff, face_bad_in;
   logic [TB-1:0]  vtotal_ff, vtotal_in;
   logic [TB-1:0]  tent_ff, tent_in;
   logic [LB-1:0]  flen_ff, flen_in;
   logic [LB-1:0]  pos_ff, pos_in;
   logic [HB-1:0]  slot_ff, slot_in;
   logic [KW-1:0]  key_ff, key_in;
   logic [FB-1:0]  fresh_ff, fresh_in;
   logic [FB-1:0]  rec_ff, rec_in;
   logic [VB-1:0]  corner_a_ff, corner_a_in;
   logic [VB-1:0]  prev_ff, prev_in;
   ofvi_pkg::kind_type code_ff, code_in;

   // result register
   logic           rsp_valid_ff;
   logic [1:0]     rsp_kind_ff;
   logic [VW-1:0]  rsp_nvi_ff, rsp_a_ff, rsp_b_ff, rsp_c_ff;
   logic [IW-1:0]  rsp_p_ff, rsp_u_ff, rsp_n_ff;
   logic           rsp_last_ff;

   logic           out_load;
   logic [1:0]     out_kind;
   logic [VW-1:0]  out_nvi, out_a, out_b, out_c;
   logic [IW-1:0]  out_p, out_u, out_n;
   logic           out_last;
   logic           out_free;

   // reference resolution
   logic [22:0]    p_r, u_r, n_r;
   logic           ref_bad;
   logic [LB-1:0]  nlen;
   logic           nbad;
   logic           trip_we;
   logic           req_accept;

   // key table and face buffer hookup
   logic [HB-1:0]  kt_rd_addr, kt_wr_addr;
   logic           kt_rd_valid, kt_wr_en, kt_wr_valid;
   logic [KW-1:0]  kt_rd_key;
   logic [VB-1:0]  kt_rd_idx, kt_wr_idx;
   logic           info_we;
   logic [INFO_W-1:0] info_wdata, info_rdata;
   logic [KW-1:0]  trip_rdata;
   logic           info_fresh;
   logic [HB-1:0]  info_slot;
   logic [VB-1:0]  info_idx;

   ofvi_key_table #(
      .HASH_BITS (HB),
      .VIDX_BITS (VB)
   ) u_key_table (
      .clock    (clock),
      .rd_addr  (kt_rd_addr),
      .rd_valid (kt_rd_valid),
      .rd_key   (kt_rd_key),
      .rd_idx   (kt_rd_idx),
      .wr_en    (kt_wr_en),
      .wr_addr  (kt_wr_addr),
      .wr_valid (kt_wr_valid),
      .wr_key   (key_ff),
      .wr_idx   (kt_wr_idx)
   );

   ofvi_face_store #(
      .DEPTH     (MAX_FACE_VERTS),
      .ADDR_BITS (PB),
      .INFO_BITS (INFO_W)
   ) u_face_store (
      .clock      (clock),
      .trip_we    (trip_we),
      .trip_waddr (face_len_ff[PB-1:0]),
      .trip_wdata ({n_r[IW-1:0], u_r[IW-1:0], p_r[IW-1:0]}),
      .info_we    (info_we),
      .info_waddr (pos_ff[PB-1:0]),
      .info_wdata (info_wdata),
      .rd_addr    (pos_ff[PB-1:0]),
      .trip_rdata (trip_rdata),
      .info_rdata (info_rdata)
   );

   assign info_fresh = info_rdata[INFO_W-1];
   assign info_slot  = info_rdata[INFO_W-2 -: HB];
   assign info_idx   = info_rdata[VB-1:0];

   assign req_stall  = (state_ff != ofvi_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // resolve the three references against the current counts
   always_comb begin
      p_r = resolve(req_pos_ref, pcnt_ff);
      u_r = resolve(req_uv_ref, tcnt_ff);
      n_r = resolve(req_normal_ref, ncnt_ff);
      // position must land in 1..count, texcoord and normal in 0..count
      ref_bad = p_r[22] || (p_r == 23'd0) || (p_r > {3'b000, pcnt_ff})
             || u_r[22] || (u_r > {3'b000, tcnt_ff})
             || n_r[22] || (n_r > {3'b000, ncnt_ff});
      nlen    = face_len_ff;
      nbad    = face_bad_ff;
      trip_we = 1'b0;
      if (req_accept && (req_cmd == ofvi_pkg::CMD_FACE) && !face_bad_ff) begin
         if (ref_bad) begin
            nbad = 1'b1;
         end else if (face_len_ff < LB'(MAX_FACE_VERTS)) begin
            trip_we = 1'b1;
            nlen    = face_len_ff + LB'(1);
         end else begin
            // too long: park just past the limit
            nlen = LB'(MAX_FACE_VERTS + 1);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      pcnt_in     = pcnt_ff;
      tcnt_in     = tcnt_ff;
      ncnt_in     = ncnt_ff;
      face_len_in = face_len_ff;
      face_bad_in = face_bad_ff;
      vtotal_in   = vtotal_ff;
      tent_in     = tent_ff;
      flen_in     = flen_ff;
      pos_in      = pos_ff;
      slot_in     = slot_ff;
      key_in      = key_ff;
      fresh_in    = fresh_ff;
      rec_in      = rec_ff;
      corner_a_in = corner_a_ff;
      prev_in     = prev_ff;
      code_in     = code_ff;

      kt_rd_addr  = slot_ff;
      kt_wr_en    = 1'b0;
      kt_wr_addr  = slot_ff;
      kt_wr_valid = 1'b0;
      kt_wr_idx   = tent_ff[VB-1:0];
      info_we     = 1'b0;
      info_wdata  = {1'b0, slot_ff, kt_rd_idx};

      out_load = 1'b0;
      out_kind = ofvi_pkg::KIND_VERTEX;
      out_nvi  = '0;
      out_p    = '0;
      out_u    = '0;
      out_n    = '0;
      out_a    = '0;
      out_b    = '0;
      out_c    = '0;
      out_last = 1'b0;

      case (state_ff)
         ofvi_pkg::S_CLEAR: begin
            // sweep the key table to invalid after reset
            kt_wr_en   = 1'b1;
            kt_wr_addr = clr_ff;
            clr_in     = clr_ff + HB'(1);
            if (clr_ff == '1) begin
               state_in = ofvi_pkg::S_IDLE;
            end
         end

         ofvi_pkg::S_IDLE: begin
            if (req_accept) begin
               case (req_cmd)
                  ofvi_pkg::CMD_POS: begin
                     if (pcnt_ff != COUNT_MAX) pcnt_in = pcnt_ff + IW'(1);
                  end
                  ofvi_pkg::CMD_UV: begin
                     if (tcnt_ff != COUNT_MAX) tcnt_in = tcnt_ff + IW'(1);
                  end
                  ofvi_pkg::CMD_NORMAL: begin
                     if (ncnt_ff != COUNT_MAX) ncnt_in = ncnt_ff + IW'(1);
                  end
                  default: begin
                     face_len_in = nlen;
                     face_bad_in = nbad;
                     if (req_face_last) begin
                        face_len_in = '0;
                        face_bad_in = 1'b0;
                        flen_in     = nlen;
                        pos_in      = '0;
                        tent_in     = vtotal_ff;
                        fresh_in    = '0;
                        rec_in      = '0;
                        if (nbad) begin
                           code_in  = ofvi_pkg::KIND_INVALID;
                           state_in = ofvi_pkg::S_ONE;
                        end else if (nlen > LB'(MAX_FACE_VERTS)) begin
                           code_in  = ofvi_pkg::KIND_OVERFLOW;
                           state_in = ofvi_pkg::S_ONE;
                        end else if (nlen != '0) begin
                           state_in = ofvi_pkg::S_P_LOAD;
                        end
                     end
                  end
               endcase
            end
         end

         ofvi_pkg::S_P_LOAD: begin
            state_in = ofvi_pkg::S_P_HASH;
         end

         ofvi_pkg::S_P_HASH: begin
            key_in     = trip_rdata;
            slot_in    = key_hash(trip_rdata);
            kt_rd_addr = key_hash(trip_rdata);
            state_in   = ofvi_pkg::S_P_CHK;
         end

         ofvi_pkg::S_P_RD: begin
            state_in = ofvi_pkg::S_P_CHK;
         end

         ofvi_pkg::S_P_CHK: begin
            if (!kt_rd_valid) begin
               if (tent_ff == TB'(MAX_VERTICES)) begin
                  // vertex store would overflow: undo this face's inserts
                  code_in = ofvi_pkg::KIND_OVERFLOW;
                  if (pos_ff == '0) begin
                     state_in = ofvi_pkg::S_ONE;
                  end else begin
                     pos_in   = pos_ff - LB'(1);
                     state_in = ofvi_pkg::S_RB_LOAD;
                  end
               end else begin
                  kt_wr_en    = 1'b1;
                  kt_wr_valid = 1'b1;
                  info_we     = 1'b1;
                  info_wdata  = {1'b1, slot_ff, tent_ff[VB-1:0]};
                  tent_in     = tent_ff + TB'(1);
                  fresh_in    = fresh_ff + FB'(1);
                  if (pos_ff == '0) corner_a_in = tent_ff[VB-1:0];
                  if (pos_ff + LB'(1) == flen_ff) begin
                     vtotal_in = tent_ff + TB'(1);
                     pos_in    = '0;
                     state_in  = ofvi_pkg::S_R_LOAD;
                  end else begin
                     pos_in   = pos_ff + LB'(1);
                     state_in = ofvi_pkg::S_P_LOAD;
                  end
               end
            end else if (kt_rd_key == key_ff) begin
               info_we    = 1'b1;
               info_wdata = {1'b0, slot_ff, kt_rd_idx};
               if (pos_ff == '0) corner_a_in = kt_rd_idx;
               if (pos_ff + LB'(1) == flen_ff) begin
                  vtotal_in = tent_ff;
                  pos_in    = '0;
                  state_in  = ofvi_pkg::S_R_LOAD;
               end else begin
                  pos_in   = pos_ff + LB'(1);
                  state_in = ofvi_pkg::S_P_LOAD;
               end
            end else begin
               // collision, linear probe
               slot_in  = slot_ff + HB'(1);
               state_in = ofvi_pkg::S_P_RD;
            end
         end

         ofvi_pkg::S_RB_LOAD: begin
            state_in = ofvi_pkg::S_RB_DO;
         end

         ofvi_pkg::S_RB_DO: begin
            // newest first, so probe chains return to their old shape
            if (info_fresh) begin
               kt_wr_en   = 1'b1;
               kt_wr_addr = info_slot;
            end
            if (pos_ff == '0) begin
               state_in = ofvi_pkg::S_ONE;
            end else begin
               pos_in   = pos_ff - LB'(1);
               state_in = ofvi_pkg::S_RB_LOAD;
            end
         end

         ofvi_pkg::S_R_LOAD: begin
            state_in = ofvi_pkg::S_R_OUT;
         end

         ofvi_pkg::S_R_OUT: begin
            if (!info_fresh || out_free) begin
               if (info_fresh) begin
                  out_load = 1'b1;
                  out_kind = ofvi_pkg::KIND_VERTEX;
                  out_nvi  = VW'(info_idx);
                  out_p    = trip_rdata[IW-1:0];
                  out_u    = trip_rdata[2*IW-1:IW];
                  out_n    = trip_rdata[3*IW-1:2*IW];
                  out_last = (rec_ff + FB'(1) == fresh_ff) && (flen_ff < LB'(3));
                  rec_in   = rec_ff + FB'(1);
               end
               if (pos_ff + LB'(1) == flen_ff) begin
                  if (flen_ff < LB'(3)) begin
                     state_in = ofvi_pkg::S_IDLE;
                  end else begin
                     pos_in   = LB'(1);
                     state_in = ofvi_pkg::S_T_LD1;
                  end
               end else begin
                  pos_in   = pos_ff + LB'(1);
                  state_in = ofvi_pkg::S_R_LOAD;
               end
            end
         end

         ofvi_pkg::S_T_LD1: begin
            state_in = ofvi_pkg::S_T_PREV;
         end

         ofvi_pkg::S_T_PREV: begin
            prev_in  = info_idx;
            pos_in   = LB'(2);
            state_in = ofvi_pkg::S_T_LD;
         end

         ofvi_pkg::S_T_LD: begin
            state_in = ofvi_pkg::S_T_OUT;
         end

         ofvi_pkg::S_T_OUT: begin
            // fan triangle around the face's first corner
            if (out_free) begin
               out_load = 1'b1;
               out_kind = ofvi_pkg::KIND_TRI;
               out_a    = VW'(corner_a_ff);
               out_b    = VW'(prev_ff);
               out_c    = VW'(info_idx);
               out_last = (pos_ff + LB'(1) == flen_ff);
               prev_in  = info_idx;
               if (pos_ff + LB'(1) == flen_ff) begin
                  state_in = ofvi_pkg::S_IDLE;
               end else begin
                  pos_in   = pos_ff + LB'(1);
                  state_in = ofvi_pkg::S_T_LD;
               end
            end
         end

         ofvi_pkg::S_ONE: begin
            if (out_free) begin
               out_load = 1'b1;
               out_kind = code_ff;
               out_last = 1'b1;
               state_in = ofvi_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ofvi_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ofvi_pkg::S_CLEAR;
         clr_ff       <= '0;
         pcnt_ff      <= '0;
         tcnt_ff      <= '0;
         ncnt_ff      <= '0;
         face_len_ff  <= '0;
         face_bad_ff  <= 1'b0;
         vtotal_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         pcnt_ff     <= pcnt_in;
         tcnt_ff     <= tcnt_in;
         ncnt_ff     <= ncnt_in;
         face_len_ff <= face_len_in;
         face_bad_ff <= face_bad_in;
         vtotal_ff   <= vtotal_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers of the face walk
   always_ff @(posedge clock) begin
      tent_ff     <= tent_in;
      flen_ff     <= flen_in;
      pos_ff      <= pos_in;
      slot_ff     <= slot_in;
      key_ff      <= key_in;
      fresh_ff    <= fresh_in;
      rec_ff      <= rec_in;
      corner_a_ff <= corner_a_in;
      prev_ff     <= prev_in;
      code_ff     <= code_in;
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_nvi_ff  <= out_nvi;
         rsp_p_ff    <= out_p;
         rsp_u_ff    <= out_u;
         rsp_n_ff    <= out_n;
         rsp_a_ff    <= out_a;
         rsp_b_ff    <= out_b;
         rsp_c_ff    <= out_c;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_new_vertex_index = rsp_nvi_ff;
   assign rsp_pos_index        = rsp_p_ff;
   assign rsp_uv_index         = rsp_u_ff;
   assign rsp_normal_index     = rsp_n_ff;
   assign rsp_corner_a         = rsp_a_ff;
   assign rsp_corner_b         = rsp_b_ff;
   assign rsp_corner_c         = rsp_c_ff;
   assign rsp_run_last         = rsp_last_ff;

endmodule

// File: rtl/core/ofvi_checker.sv
// ----------------------------------------------------------------------------
// ofvi_checker
// port-level checks of the face vertex indexer, bound to the top level
// ----------------------------------------------------------------------------
module ofvi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_cmd,
   input logic        req_face_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [11:0] rsp_new_vertex_index,
   input logic [19:0] rsp_pos_index,
   input logic [11:0] rsp_corner_a,
   input logic        rsp_run_last
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_corner_a))
      else $error("stalled result changed");

   // anything but a face end leaves the block ready
   a_ready_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      !(req_cmd == ofvi_pkg::CMD_FACE && req_face_last) |=> !req_stall)
      else $error("block busy after non-terminal transaction");

   // a rejected face is a single result
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == ofvi_pkg::KIND_INVALID ||
                    rsp_kind == ofvi_pkg::KIND_OVERFLOW) |-> rsp_run_last)
      else $error("rejected face result not final");

   // vertex fields are zero outside new-vertex records
   a_vertex_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != ofvi_pkg::KIND_VERTEX |->
      rsp_new_vertex_index == 12'd0 && rsp_pos_index == 20'd0)
      else $error("vertex fields set on non-vertex result");

endmodule

bind obj_face_vertex_indexer_unit ofvi_checker u_ofvi_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .req_cmd              (req_cmd),
   .req_face_last        (req_face_last),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_kind             (rsp_kind),
   .rsp_new_vertex_index (rsp_new_vertex_index),
   .rsp_pos_index        (rsp_pos_index),
   .rsp_corner_a         (rsp_corner_a),
   .rsp_run_last         (rsp_run_last)
);

// File: tb/sv/obj_face_vertex_indexer_unit_tb.sv
// ----------------------------------------------------------------------------
// obj_face_vertex_indexer_unit_tb
// self-checking bench: a queue-fed driver offers declarations and face
// references, a scoreboard mirrors the declaration counts, the face buffer
// and the vertex key table, and a monitor compares every result transaction
// ----------------------------------------------------------------------------
module obj_face_vertex_indexer_unit_tb;

   localparam int MAX_FV     = ofvi_pkg::DEF_MAX_FACE_VERTS;
   localparam int MAX_V      = ofvi_pkg::DEF_MAX_VERTICES;
   localparam int REF_W      = ofvi_pkg::REF_W;
   localparam int IDX_W      = ofvi_pkg::IDX_W;
   localparam int KEY_W      = ofvi_pkg::KEY_W;
   localparam int VID_W      = ofvi_pkg::VID_W;
   localparam int CYCLE_CAP  = 1000000;
   localparam int HOLD_LEN   = 400;
   localparam int RAND_ITEMS = 385;

   typedef struct packed {
      ofvi_pkg::cmd_type       cmd;
      logic signed [REF_W-1:0] pos;
      logic signed [REF_W-1:0] uv;
      logic signed [REF_W-1:0] nrm;
      logic                    last;
   } face_req_type;

   typedef struct packed {
      ofvi_pkg::kind_type kind;
      logic [VID_W-1:0]  vid;
      logic [IDX_W-1:0]  p;
      logic [IDX_W-1:0]  u;
      logic [IDX_W-1:0]  n;
      logic [VID_W-1:0]  ca;
      logic [VID_W-1:0]  cb;
      logic [VID_W-1:0]  cc;
      logic              last;
   } mesh_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = ofvi_pkg::CMD_POS;
   logic signed [REF_W-1:0] req_pos_ref = '0;
   logic signed [REF_W-1:0] req_uv_ref = '0;
   logic signed [REF_W-1:0] req_normal_ref = '0;
   logic req_face_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [VID_W-1:0] rsp_new_vertex_index;
   logic [IDX_W-1:0] rsp_pos_index, rsp_uv_index, rsp_normal_index;
   logic [VID_W-1:0] rsp_corner_a, rsp_corner_b, rsp_corner_c;
   logic rsp_run_last;

   obj_face_vertex_indexer_unit i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // stimulus and expected results
   face_req_type pending_reqs[$];
   mesh_rsp_type expected_rsps[$];
   int total_reqs;
   int n_accepted = 0;
   int n_checked = 0;
   int n_errors = 0;
   int kind_seen[4] = '{0, 0, 0, 0};
   longint unsigned cycle_count = 0;

   // mirror of the block state
   logic [IDX_W-1:0] pos_cnt = '0, uv_cnt = '0, nrm_cnt = '0;
   logic [KEY_W-1:0] face_keys[MAX_FV];
   int face_len = 0;
   bit face_broken = 0;
   int vertex_of_key[logic [KEY_W-1:0]];
   int vertex_cnt = 0;

   // idling profile: 0 sender 35 / receiver 64, 1 swapped, 2 no idling
   function automatic int idle_mode();
      if (n_accepted < total_reqs / 3) return 0;
      if (n_accepted < 2 * total_reqs / 3) return 1;
      return 2;
   endfunction

   function automatic bit chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic longint resolve_ref(logic signed [REF_W-1:0] raw,
                                          logic [IDX_W-1:0] cnt);
      longint r;
      r = raw;
      return (r < 0) ? longint'(cnt) + r + 1 : r;
   endfunction

   function automatic void push_rsp(ofvi_pkg::kind_type k, int vid,
                                    logic [KEY_W-1:0] key, int a, int b, int c);
      mesh_rsp_type r;
      r.kind = k;
      r.vid = VID_W'(vid);
      r.p = key[IDX_W-1:0];
      r.u = key[2*IDX_W-1:IDX_W];
      r.n = key[3*IDX_W-1:2*IDX_W];
      r.ca = VID_W'(a);
      r.cb = VID_W'(b);
      r.cc = VID_W'(c);
      r.last = 1'b0;
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   // face end: check, dedup, emit vertex records then fan triangles
   function automatic void close_face();
      int corners[MAX_FV];
      int fresh;
      int before_cnt;
      bit seen;
      before_cnt = expected_rsps.size();
      fresh = 0;
      if (face_broken) begin
         push_rsp(ofvi_pkg::KIND_INVALID, 0, '0, 0, 0, 0);
      end else if (face_len > MAX_FV) begin
         push_rsp(ofvi_pkg::KIND_OVERFLOW, 0, '0, 0, 0, 0);
      end else begin
         for (int i = 0; i < face_len; i++) begin
            seen = vertex_of_key.exists(face_keys[i]);
            for (int j = 0; j < i; j++)
               if (face_keys[j] == face_keys[i]) seen = 1;
            if (!seen) fresh++;
         end
         if (vertex_cnt + fresh > MAX_V) begin
            push_rsp(ofvi_pkg::KIND_OVERFLOW, 0, '0, 0, 0, 0);
         end else begin
            for (int i = 0; i < face_len; i++) begin
               if (!vertex_of_key.exists(face_keys[i])) begin
                  vertex_of_key[face_keys[i]] = vertex_cnt;
                  push_rsp(ofvi_pkg::KIND_VERTEX, vertex_cnt, face_keys[i], 0, 0, 0);
                  vertex_cnt++;
               end
               corners[i] = vertex_of_key[face_keys[i]];
            end
            for (int i = 1; i + 1 < face_len; i++)
               push_rsp(ofvi_pkg::KIND_TRI, 0, '0, corners[0], corners[i],
                        corners[i+1]);
         end
      end
      if (expected_rsps.size() > before_cnt)
         expected_rsps[expected_rsps.size()-1].last = 1'b1;
      face_len = 0;
      face_broken = 0;
   endfunction

   function automatic void apply_req(face_req_type t);
      longint p, u, n;
      case (t.cmd)
         ofvi_pkg::CMD_POS:    if (pos_cnt != '1) pos_cnt++;
         ofvi_pkg::CMD_UV:     if (uv_cnt != '1) uv_cnt++;
         ofvi_pkg::CMD_NORMAL: if (nrm_cnt != '1) nrm_cnt++;
         default: begin
            if (!face_broken) begin
               p = resolve_ref(t.pos, pos_cnt);
               u = resolve_ref(t.uv, uv_cnt);
               n = resolve_ref(t.nrm, nrm_cnt);
               if (p < 1 || p > pos_cnt || u < 0 || u > uv_cnt || n < 0 || n > nrm_cnt)
                  face_broken = 1;
               else if (face_len < MAX_FV) begin
                  face_keys[face_len] = {n[IDX_W-1:0], u[IDX_W-1:0], p[IDX_W-1:0]};
                  face_len++;
               end else
                  face_len = MAX_FV + 1;
            end
            if (t.last) close_face();
         end
      endcase
   endfunction

   // generator-side declaration counts, used to build in-range references
   int gen_p = 0, gen_u = 0, gen_n = 0;

   function automatic void add_req(ofvi_pkg::cmd_type c, int p, int u, int n, bit last);
      face_req_type t;
      t.cmd = c;
      t.pos = REF_W'(p);
      t.uv = REF_W'(u);
      t.nrm = REF_W'(n);
      t.last = last;
      if (c == ofvi_pkg::CMD_POS) gen_p++;
      if (c == ofvi_pkg::CMD_UV) gen_u++;
      if (c == ofvi_pkg::CMD_NORMAL) gen_n++;
      pending_reqs.insert(pending_reqs.size(), t);
   endfunction

   // in-range reference, absolute or relative; zero allowed for uv/normal
   function automatic int pick_ref(int cnt, bit allow_zero);
      int idx;
      if (allow_zero && chance(25)) idx = 0;
      else if (chance(70)) idx = $urandom_range((cnt < 5) ? cnt : 5, 1);
      else idx = $urandom_range(cnt, 1);
      if (allow_zero && idx == 0)
         return chance(50) ? 0 : -(cnt + 1);
      return chance(50) ? idx : idx - cnt - 1;
   endfunction

   function automatic int wild_ref();
      case ($urandom_range(3))
         0: return 1048575;
         1: return -1048575;
         2: return 0;
         default: return $urandom_range(2097150) - 1048575;
      endcase
   endfunction

   function automatic void add_face(int len, int bad_pct);
      for (int i = 0; i < len; i++) begin
         if (chance(5))
            add_req(ofvi_pkg::cmd_type'($urandom_range(2)), 0, 0, 0, chance(50));
         if (chance(bad_pct))
            add_req(ofvi_pkg::CMD_FACE, wild_ref(), wild_ref(), wild_ref(),
                    i == len - 1);
         else
            add_req(ofvi_pkg::CMD_FACE, pick_ref(gen_p, 0), pick_ref(gen_u, 1),
                    pick_ref(gen_n, 1), i == len - 1);
      end
   endfunction

   // driver: next transaction or idle whenever the current one is accepted or absent
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            apply_req('{ofvi_pkg::cmd_type'(req_cmd), req_pos_ref, req_uv_ref,
                        req_normal_ref, req_face_last});
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() == 0 || (idle_mode() == 0 && chance(35))
                || (idle_mode() == 1 && chance(64))) begin
               req_valid <= 1'b0;
            end else begin
               face_req_type t;
               t = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_cmd <= t.cmd;
               req_pos_ref <= t.pos;
               req_uv_ref <= t.uv;
               req_normal_ref <= t.nrm;
               req_face_last <= t.last;
            end
         end
      end
   end

   // long receiver hold-off once, counted here while the sender keeps going
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (hold_left > 0)
         hold_left <= hold_left - 1;
      else if (!hold_done && n_accepted >= 60) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1;
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            mesh_rsp_type got, want;
            got = '{ofvi_pkg::kind_type'(rsp_kind), rsp_new_vertex_index,
                    rsp_pos_index, rsp_uv_index, rsp_normal_index, rsp_corner_a,
                    rsp_corner_b, rsp_corner_c, rsp_run_last};
            kind_seen[rsp_kind]++;
            if (expected_rsps.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) $display("unexpected transaction %p", got);
            end else begin
               want = expected_rsps.pop_front();
               n_checked++;
               if (got !== want) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("mismatch at result %0d\n  expected %p\n  actual   %p",
                              n_checked, want, got);
               end
            end
         end
         rsp_stall <= (hold_left > 0) || (idle_mode() == 0 && chance(64))
                      || (idle_mode() == 1 && chance(35));
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("obj_face_vertex_indexer_unit verification failed");
         $finish;
      end
   end

   initial begin
      // directed: declarations, dedup, relative refs, absent uv/normal
      repeat (3) add_req(ofvi_pkg::CMD_POS, 0, 0, 0, 0);
      repeat (2) add_req(ofvi_pkg::CMD_UV, 0, 0, 0, 0);
      add_req(ofvi_pkg::CMD_NORMAL, 0, 0, 0, 1);  // face_last on a declaration is ignored
      add_req(ofvi_pkg::CMD_NORMAL, 0, 0, 0, 0);
      add_req(ofvi_pkg::CMD_FACE, 1, 1, 1, 0);
      add_req(ofvi_pkg::CMD_FACE, 2, 0, 0, 0);
      add_req(ofvi_pkg::CMD_FACE, 3, -1, -1, 1);
      add_req(ofvi_pkg::CMD_FACE, 1, 1, 1, 0);     // same face again, all reused
      add_req(ofvi_pkg::CMD_FACE, -2, 0, 0, 0);
      add_req(ofvi_pkg::CMD_FACE, -1, 2, 2, 1);
      add_req(ofvi_pkg::CMD_FACE, -3, -3, -3, 0);  // relative refs, uv and normal resolving to absent
      add_req(ofvi_pkg::CMD_POS, 0, 0, 0, 0);      // declaration inside a face
      add_req(ofvi_pkg::CMD_FACE, -1, 0, 0, 1);    // short face, no triangles
      add_req(ofvi_pkg::CMD_FACE, -1, 0, 0, 1);    // single reused ref, no result
      add_req(ofvi_pkg::CMD_FACE, 0, 0, 0, 1);     // missing position
      add_req(ofvi_pkg::CMD_FACE, 1048575, 1, 1, 0);
      add_req(ofvi_pkg::CMD_FACE, 1, 1, 1, 1);     // ignored after the bad ref
      add_req(ofvi_pkg::CMD_FACE, -1048575, 1048575, -1048575, 1);
      add_req(ofvi_pkg::CMD_FACE, 1, -1048575, 1048575, 1);
      add_req(ofvi_pkg::CMD_FACE, 1, 3, 0, 1);     // texcoord above its count
      add_req(ofvi_pkg::CMD_FACE, 1, 0, -4, 1);    // normal below zero
      // random: mostly well-formed faces, some long, broken and noise
      while (pending_reqs.size() < RAND_ITEMS + 25) begin
         case ($urandom_range(19))
            0, 1, 2: add_req(ofvi_pkg::cmd_type'($urandom_range(2)), wild_ref(),
                             wild_ref(), wild_ref(), chance(30));
            3:       add_face($urandom_range(18, 16), 3);  // around the length limit
            4:       add_face($urandom_range(6, 1), 40);
            5:       add_req(ofvi_pkg::CMD_FACE, wild_ref(), wild_ref(), wild_ref(),
                             chance(50));
            default: add_face($urandom_range(8, 3), 2);
         endcase
      end
      total_reqs = pending_reqs.size();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d requests, checked %0d results", total_reqs, n_checked);
      $display("vertices %0d, triangles %0d, invalid faces %0d, overflow faces %0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      if (n_errors == 0 && expected_rsps.size() == 0)
         $display("obj_face_vertex_indexer_unit verification clean");
      else
         $display("obj_face_vertex_indexer_unit verification failed");
      $finish;
   end

endmodule

// File: obj_face_vertex_indexer_unit.f
rtl/core/ofvi_pkg.sv
rtl/core/ofvi_key_table.sv
rtl/core/ofvi_face_store.sv
rtl/core/obj_face_vertex_indexer_unit.sv
rtl/core/ofvi_checker.sv
tb/sv/obj_face_vertex_indexer_unit_tb.sv
